FILE: sv/cbm_pkg.sv
// shared types, codes and helpers for the cell bucket membership table
package cbm_pkg;

    localparam int OP_W       = 3;
    localparam int CELL_REQ_W = 12;
    localparam int PART_W     = 16;
    localparam int SLOT_REQ_W = 4;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int CAP_W      = 5;

    localparam int CELLS_DEF = 4096;
    localparam int SLOTS_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam int unsigned      MAX_REQ   = (1 << CELL_REQ_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_DELETE = 3'd2,
        OP_MOVE   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_ABSENT = 3'd3,
        ST_SLOT   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_SRC,
        S_CNT_DST,
        S_DISPATCH,
        S_READ_MEM,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH,
        S_FINISH_DST,
        S_RESP
    } t_state;

    // cell number modulo cells, by restoring compare-subtract of shifted multiples (exact for x below 256 times cells)
    function automatic logic [CELL_REQ_W-1:0] wrap_cell(input logic [CELL_REQ_W-1:0] x,
                                                        input int unsigned cells);
        logic [CELL_REQ_W-1:0] v;
        int unsigned thr;
        v = x;
        for (int k = 7; k >= 0; k--) begin
            thr = cells << k;
            if (thr <= MAX_REQ && 32'(v) >= thr) begin
                v = v - CELL_REQ_W'(thr);
            end
        end
        return v;
    endfunction

endpackage

FILE: sv/cell_bucket_membership_table_unit.sv
// cell bucket membership table: per-cell particle count and ordered member list
//
// Input channel (i_in_valid / o_in_ready) takes one transaction: op, cell, destination cell,
// particle and slot. Output channel (o_out_valid / i_out_ready) returns one transaction per
// input: status, count and member. Configuration channel (i_cfg_valid / o_cfg_ready) writes
// the cell capacity and is always ready; write it only while the block is idle.
// One transaction is worked at a time under a small sequencer, with one compare unit that
// walks a cell row slot by slot, a read step then a compare step, through the member ram's
// single read port. Steps from accept to result loaded: every op but clear reads the source
// count, then the destination count, then dispatches. Add, a read of a bad slot, an unused op
// and delete/move on an empty cell answer there; read fetches its member. Delete/move scan to
// the particle (a miss or a full move destination answers there), shift the later entries
// down, write the source count and, for move, the destination member and then its count.
// Clear writes one counter entry per cycle. Input is ready in the cycle after a result is loaded.
// After reset the counter ram is swept in the same way; no input is taken meanwhile,
// configuration writes are. The result sits in an output register; while the receiver
// stalls, a finished transaction waits there and the next one holds in its last step.
module cell_bucket_membership_table_unit
    import cbm_pkg::*;
#(
    parameter int CELLS = CELLS_DEF,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_op,
    input  logic [CELL_REQ_W-1:0] i_cell_req,
    input  logic [CELL_REQ_W-1:0] i_dest_cell,
    input  logic [PART_W-1:0]     i_particle,
    input  logic [SLOT_REQ_W-1:0] i_slot,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [COUNT_W-1:0]    o_count,
    output logic [PART_W-1:0]     o_member,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CAP_W-1:0]      i_cfg_data
);

    localparam int CELL_W = $clog2(CELLS);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
    localparam int MEM_AW = CELL_W + SLOT_W;

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op;
    logic [CELL_W-1:0]     r_src, r_dst, r_clr;
    logic [PART_W-1:0]     r_part;
    logic [SLOT_REQ_W-1:0] r_slot;
    logic [CNT_W-1:0]      r_scnt, r_dcnt, r_dc;
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_clr_resp;
    logic [CAP_W-1:0]      r_cap;
    logic [STATUS_W-1:0]   r_res_status;
    logic [CMP_W-1:0]      r_res_count;
    logic [PART_W-1:0]     r_res_member;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [COUNT_W-1:0]    r_out_count;
    logic [PART_W-1:0]     r_out_member;

    logic [CNT_W-1:0]      n_scnt, n_dcnt, n_dc;
    logic [SLOT_W-1:0]     n_idx;
    logic [CELL_W-1:0]     n_clr;
    logic                  n_clr_resp;
    logic [STATUS_W-1:0]   n_res_status;
    logic [CMP_W-1:0]      n_res_count;
    logic [PART_W-1:0]     n_res_member;
    logic                  n_out_valid;

    logic                  cnt_we;
    logic [CELL_W-1:0]     cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]      cnt_wdata, cnt_rdata;
    logic                  mem_we;
    logic [MEM_AW-1:0]     mem_waddr, mem_raddr;
    logic [PART_W-1:0]     mem_wdata, mem_rdata;

    logic                  in_acc, out_free;
    logic [CMP_W-1:0]      lim, scnt_c, idx_c, slot_c;
    logic [CNT_W-1:0]      dc_calc;
    logic                  add_full, slot_bad, hit, scan_last, dc_full;
    logic                  shift_first, shift_next, clr_last;

    cbm_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    cbm_ram #(.WIDTH(PART_W), .DEPTH(CELLS << SLOT_W)) u_members (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // shared compare unit operands
    assign lim         = (CMP_W'(r_cap) < CMP_W'(SLOTS)) ? CMP_W'(r_cap) : CMP_W'(SLOTS);
    assign scnt_c      = CMP_W'(r_scnt);
    assign idx_c       = CMP_W'(r_idx);
    assign slot_c      = CMP_W'(r_slot);
    assign add_full    = scnt_c >= lim;
    assign slot_bad    = slot_c >= scnt_c;
    assign hit         = mem_rdata == r_part;
    assign scan_last   = idx_c + CMP_W'(1) >= scnt_c;
    // a move within one cell frees its own slot first
    assign dc_calc     = (r_dst == r_src) ? r_dcnt - CNT_W'(1) : r_dcnt;
    assign dc_full     = CMP_W'(dc_calc) >= lim;
    assign shift_first = idx_c + CMP_W'(1) < scnt_c;
    assign shift_next  = idx_c + CMP_W'(2) < scnt_c;
    assign clr_last    = r_clr == CELL_W'(CELLS - 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_op == OP_CLEAR) ? S_CLEAR : S_CNT_SRC;
                end
            end
            S_CNT_SRC: n_state = S_CNT_DST;
            S_CNT_DST: n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (r_op)
                    OP_READ:               n_state = slot_bad ? S_RESP : S_READ_MEM;
                    OP_DELETE, OP_MOVE:    n_state = (r_scnt == '0) ? S_RESP : S_SCAN_RD;
                    default:               n_state = S_RESP;
                endcase
            end
            S_READ_MEM: n_state = S_RESP;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                priority if (hit) begin
                    if (r_op == OP_MOVE && dc_full) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = shift_first ? S_SHIFT_RD : S_FINISH;
                    end
                end else if (scan_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:   n_state = S_SHIFT_WR;
            S_SHIFT_WR:   n_state = shift_next ? S_SHIFT_RD : S_FINISH;
            S_FINISH:     n_state = (r_op == OP_MOVE) ? S_FINISH_DST : S_RESP;
            S_FINISH_DST: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        cnt_raddr    = r_src;
        cnt_we       = 1'b0;
        cnt_waddr    = r_src;
        cnt_wdata    = '0;
        mem_raddr    = {r_src, r_idx};
        mem_we       = 1'b0;
        mem_waddr    = {r_src, r_idx};
        mem_wdata    = r_part;
        n_scnt       = r_scnt;
        n_dcnt       = r_dcnt;
        n_dc         = r_dc;
        n_idx        = r_idx;
        n_clr        = r_clr;
        n_clr_resp   = r_clr_resp;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        n_res_member = r_res_member;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                n_clr     = r_clr + CELL_W'(1);
            end
            S_IDLE: begin
                n_res_status = ST_OK;
                n_res_count  = '0;
                n_res_member = '0;
                n_clr        = '0;
                n_clr_resp   = 1'b1;
            end
            S_CNT_SRC: begin
                cnt_raddr = r_src;
            end
            S_CNT_DST: begin
                cnt_raddr = r_dst;
                n_scnt    = cnt_rdata;
            end
            S_DISPATCH: begin
                n_dcnt      = cnt_rdata;
                n_idx       = '0;
                n_res_count = scnt_c;
                unique case (r_op)
                    OP_ADD: begin
                        if (add_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            mem_we      = 1'b1;
                            mem_waddr   = {r_src, SLOT_W'(r_scnt)};
                            cnt_we      = 1'b1;
                            cnt_wdata   = r_scnt + CNT_W'(1);
                            n_res_count = scnt_c + CMP_W'(1);
                        end
                    end
                    OP_READ: begin
                        mem_raddr = {r_src, SLOT_W'(r_slot)};
                        if (slot_bad) begin
                            n_res_status = ST_SLOT;
                        end
                    end
                    OP_DELETE, OP_MOVE: begin
                        if (r_scnt == '0) begin
                            n_res_status = ST_EMPTY;
                            if (r_op == OP_MOVE) begin
                                n_res_count = CMP_W'(cnt_rdata);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_READ_MEM: begin
                n_res_member = mem_rdata;
            end
            S_SCAN_RD: begin
                mem_raddr = {r_src, r_idx};
            end
            S_SCAN_CMP: begin
                n_dc = dc_calc;
                priority if (hit) begin
                    if (r_op == OP_MOVE && dc_full) begin
                        n_res_status = ST_FULL;
                        n_res_count  = CMP_W'(r_dcnt);
                    end
                end else if (scan_last) begin
                    n_res_status = ST_ABSENT;
                    if (r_op == OP_MOVE) begin
                        n_res_count = CMP_W'(r_dcnt);
                    end
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_SHIFT_RD: begin
                mem_raddr = {r_src, r_idx + SLOT_W'(1)};
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_src, r_idx};
                mem_wdata = mem_rdata;
                n_idx     = r_idx + SLOT_W'(1);
            end
            S_FINISH: begin
                cnt_we      = 1'b1;
                cnt_waddr   = r_src;
                cnt_wdata   = r_scnt - CNT_W'(1);
                n_res_count = scnt_c - CMP_W'(1);
                if (r_op == OP_MOVE) begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_dst, SLOT_W'(r_dc)};
                end
            end
            S_FINISH_DST: begin
                cnt_we      = 1'b1;
                cnt_waddr   = r_dst;
                cnt_wdata   = r_dc + CNT_W'(1);
                n_res_count = CMP_W'(r_dc) + CMP_W'(1);
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_op;
            r_src  <= CELL_W'(wrap_cell(i_cell_req, CELLS));
            r_dst  <= CELL_W'(wrap_cell(i_dest_cell, CELLS));
            r_part <= i_particle;
            r_slot <= i_slot;
        end
        r_scnt       <= n_scnt;
        r_dcnt       <= n_dcnt;
        r_dc         <= n_dc;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
        r_res_member <= n_res_member;
        if (r_state == S_RESP && out_free) begin
            r_out_status <= r_res_status;
            r_out_count  <= COUNT_W'(r_res_count);
            r_out_member <= r_res_member;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_member    = r_out_member;

    // a stored count never exceeds the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISPATCH) |-> (CMP_W'(r_scnt) <= CMP_W'(SLOTS)))
        else $error("cell count above row length");

    // a failed operation never returns a member
    a_member_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_member == '0))
        else $error("member returned with error status");

    // a finished result waits while the receiver stalls
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_out_ready) |=> (r_state == S_RESP))
        else $error("result dropped under stall");

    // an accepted transaction starts work at once
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

endmodule

FILE: sv/cbm_ram.sv
// generic single write port, single read port ram with registered read data
module cbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb.sv
// testbench for the cell bucket membership table: directed and random traffic with a scoreboard
`timescale 1ns / 100ps

module tb;
    import cbm_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES   = 64;

    // op codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [CELL_REQ_W-1:0] TOP_CELL = CELL_REQ_W'(MAX_REQ);
    localparam logic [SLOT_REQ_W-1:0] TOP_SLOT = SLOT_REQ_W'(SLOTS_DEF - 1);

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
        logic [PART_W-1:0]    member;
    } t_outcome;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       op_r = '0;
    logic [CELL_REQ_W-1:0] cell_r = '0;
    logic [CELL_REQ_W-1:0] dest_r = '0;
    logic [PART_W-1:0]     particle_r = '0;
    logic [SLOT_REQ_W-1:0] slot_r = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status_w;
    logic [COUNT_W-1:0]    count_w;
    logic [PART_W-1:0]     member_w;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data = '0;

    // mirror of the table
    logic [COUNT_W-1:0]    tally [CELLS_DEF];
    logic [PART_W-1:0]     roster [CELLS_DEF][SLOTS_DEF];
    logic [CAP_W-1:0]      capacity_q;
    logic [CELL_REQ_W-1:0] hot_cells [4];

    t_outcome pending_q [$];
    int       error_count = 0;
    int       gap_pct = 0;
    int       stall_chance = 0;
    int       stall_left = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cell_bucket_membership_table_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_op        (op_r),
        .i_cell_req  (cell_r),
        .i_dest_cell (dest_r),
        .i_particle  (particle_r),
        .i_slot      (slot_r),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_status    (status_w),
        .o_count     (count_w),
        .o_member    (member_w),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    function automatic int find_member(input logic [CELL_REQ_W-1:0] cell_no,
                                       input logic [PART_W-1:0] part);
        for (int i = 0; i < tally[cell_no]; i++) begin
            if (roster[cell_no][i] == part) return i;
        end
        return -1;
    endfunction

    function automatic void drop_member(input logic [CELL_REQ_W-1:0] cell_no, input int pos);
        for (int i = pos; i + 1 < tally[cell_no]; i++)
            roster[cell_no][i] = roster[cell_no][i + 1];
        tally[cell_no] = tally[cell_no] - 1'b1;
    endfunction

    function automatic void append_member(input logic [CELL_REQ_W-1:0] cell_no,
                                          input logic [PART_W-1:0] part);
        roster[cell_no][tally[cell_no]] = part;
        tally[cell_no] = tally[cell_no] + 1'b1;
    endfunction

    // applies one transaction to the mirror and returns the result it should give
    function automatic t_outcome apply_request(input logic [OP_W-1:0] op,
                                               input logic [CELL_REQ_W-1:0] src,
                                               input logic [CELL_REQ_W-1:0] dst,
                                               input logic [PART_W-1:0] part,
                                               input logic [SLOT_REQ_W-1:0] slot);
        t_outcome res;
        int limit;
        int pos;
        int dcnt;
        res.status = ST_OK;
        res.count  = '0;
        res.member = '0;
        limit = (capacity_q < SLOTS_DEF) ? int'(capacity_q) : SLOTS_DEF;
        case (op)
            OP_CLEAR: begin
                foreach (tally[c]) tally[c] = '0;
            end
            OP_ADD: begin
                if (tally[src] >= limit) res.status = ST_FULL;
                else append_member(src, part);
                res.count = tally[src];
            end
            OP_DELETE: begin
                if (tally[src] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = find_member(src, part);
                    if (pos < 0) res.status = ST_ABSENT;
                    else drop_member(src, pos);
                end
                res.count = tally[src];
            end
            OP_MOVE: begin
                if (tally[src] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = find_member(src, part);
                    if (pos < 0) begin
                        res.status = ST_ABSENT;
                    end else begin
                        // destination is judged as it stands after the removal
                        dcnt = tally[dst];
                        if (dst == src) dcnt--;
                        if (dcnt >= limit) begin
                            res.status = ST_FULL;
                        end else begin
                            drop_member(src, pos);
                            append_member(dst, part);
                        end
                    end
                end
                res.count = tally[dst];
            end
            OP_READ: begin
                if (slot >= tally[src]) res.status = ST_SLOT;
                else res.member = roster[src][slot];
                res.count = tally[src];
            end
            default: begin
                res.count = tally[src];
            end
        endcase
        return res;
    endfunction

    function automatic logic [CELL_REQ_W-1:0] pick_cell();
        if ($urandom_range(99) < 85) return hot_cells[$urandom_range(3)];
        return CELL_REQ_W'($urandom_range(MAX_REQ));
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CELL_REQ_W-1:0] src,
                             input logic [CELL_REQ_W-1:0] dst, input logic [PART_W-1:0] part,
                             input logic [SLOT_REQ_W-1:0] slot);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(18)) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        op_r       <= op;
        cell_r     <= src;
        dest_r     <= dst;
        particle_r <= part;
        slot_r     <= slot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_q.push_back(apply_request(op, src, dst, part, slot));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    // capacity only changes while nothing is in flight
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        capacity_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_cells();
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_READ, TOP_CELL, 0, 0, TOP_SLOT);
        send_item(OP_DELETE, TOP_CELL, 0, 16'hFFFF, 0);
    endtask

    task automatic test_add_delete();
        send_item(OP_ADD, 0, TOP_CELL, 16'hFFFF, 0);
        send_item(OP_ADD, 0, 0, 16'h0000, 0);
        send_item(OP_ADD, 0, 0, 16'h1234, 0);
        send_item(OP_DELETE, 0, 0, 16'h5555, 0);
        // removing the head shifts the rest down
        send_item(OP_DELETE, 0, 0, 16'hFFFF, 0);
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 1);
        send_item(OP_READ, 0, 0, 0, 2);
    endtask

    task automatic test_move();
        send_item(OP_MOVE, 0, 0, 16'h1234, 0);
        send_item(OP_MOVE, 0, TOP_CELL, 16'h0000, 0);
        send_item(OP_READ, TOP_CELL, 0, 0, 0);
        send_item(OP_MOVE, 0, 5, 16'hBEEF, 0);
    endtask

    task automatic test_unused_ops();
        send_item(OP_SPARE_FIRST, 0, 0, 16'hAAAA, 4'hA);
        send_item(OP_SPARE_FIRST + 1'b1, TOP_CELL, TOP_CELL, 16'h5555, 4'h5);
        send_item(OP_SPARE_LAST, 0, 0, 0, 0);
    endtask

    task automatic test_capacity();
        write_capacity(CAP_W'(1));
        send_item(OP_ADD, 7, 0, 1, 0);
        send_item(OP_ADD, 7, 0, 2, 0);
        send_item(OP_ADD, 8, 0, 3, 0);
        send_item(OP_MOVE, 7, 8, 1, 0);
        // same-cell move fits even at capacity
        send_item(OP_MOVE, 7, 7, 1, 0);
        write_capacity(CAP_W'(0));
        send_item(OP_ADD, 9, 0, 4, 0);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, TOP_CELL, TOP_CELL, 16'hFFFF, 4'hF);
        send_item(OP_READ, 7, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int n_items,
                                       input int gap, input int stall);
        logic [OP_W-1:0]       op;
        logic [CELL_REQ_W-1:0] src;
        logic [CELL_REQ_W-1:0] dst;
        logic [PART_W-1:0]     part;
        logic [SLOT_REQ_W-1:0] slot;
        int                    roll;
        gap_pct      = gap;
        stall_chance = stall;
        write_capacity(cap);
        hot_cells[0] = '0;
        hot_cells[1] = TOP_CELL;
        hot_cells[2] = CELL_REQ_W'($urandom_range(MAX_REQ));
        hot_cells[3] = CELL_REQ_W'($urandom_range(MAX_REQ));
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < 1) op = OP_CLEAR;
            else if (roll < 5) op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            else if (roll < 40) op = OP_ADD;
            else if (roll < 60) op = OP_DELETE;
            else if (roll < 80) op = OP_MOVE;
            else op = OP_READ;
            src  = pick_cell();
            dst  = pick_cell();
            part = PART_W'($urandom_range(16'hFFFF));
            // mostly name a particle that is really there, sometimes a duplicate on add
            if (tally[src] != 0) begin
                if (((op == OP_DELETE || op == OP_MOVE) && $urandom_range(99) < 75) ||
                    (op == OP_ADD && $urandom_range(99) < 10)) begin
                    part = roster[src][$urandom_range(tally[src] - 1'b1)];
                end
            end
            roll = $urandom_range(tally[src]);
            slot = (roll > SLOTS_DEF - 1) ? TOP_SLOT : SLOT_REQ_W'(roll);
            if ($urandom_range(99) < 30) slot = SLOT_REQ_W'($urandom_range(SLOTS_DEF - 1));
            send_item(op, src, dst, part, slot);
        end
    endtask

    // receiver side: random stall bursts
    always @(negedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_chance != 0 && $urandom_range(99) < stall_chance) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(18);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_outcome want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                $error("result transaction with nothing pending: status %0d count %0d member %0h",
                       status_w, count_w, member_w);
                error_count++;
            end else begin
                want = pending_q.pop_front();
                if (status_w !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, status_w);
                    error_count++;
                end
                if (count_w !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, count_w);
                    error_count++;
                end
                if (member_w !== want.member) begin
                    $error("member: expected %0h, actual %0h", want.member, member_w);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        foreach (tally[c]) tally[c] = '0;
        capacity_q = CAP_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_cells();
        test_add_delete();
        test_move();
        test_unused_ops();
        test_capacity();
        test_clear();

        test_random_traffic(CAP_W'(16), 300, 20, 10);
        test_random_traffic(CAP_W'(31), 250, 0, 0);
        test_random_traffic(CAP_W'(4), 250, 30, 15);
        test_random_traffic(CAP_W'(1), 200, 15, 5);
        test_random_traffic(CAP_W'(0), 60, 10, 10);
        test_random_traffic(CAP_W'(9), 250, 20, 10);
        test_random_traffic(CAP_W'(2), 220, 25, 20);
        // closing stretch runs at full rate
        test_random_traffic(CAP_W'(16), 300, 0, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: cell_bucket_membership_table_unit.f
sv/cbm_pkg.sv
sv/cbm_ram.sv
sv/cell_bucket_membership_table_unit.sv
tb/tb.sv
